FILE: rtl/core/tpbe_pkg.sv
// shared types, constants and arithmetic helpers of the tetrahedral basis evaluator
package tpbe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NDOF      = 23;
	localparam int NFACE     = 4;
	localparam int FACE_BASE = 10;
	localparam int Q_DEPTH   = 2;

	// internal value widths: wide operand, narrow operand
	localparam int VW = 36;
	localparam int SW = 25;
	localparam int PW = VW + SW;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [SW-1:0] sml_t;
	typedef logic        [16:0]   coord_t;
	typedef logic signed [19:0]   wcrd_t;
	typedef logic        [4:0]    dof_t;
	typedef logic signed [18:0]   bval_t;
	typedef logic [NFACE-1:0][2:0][1:0] perm_set_t;

	typedef struct packed {
		coord_t    x;
		coord_t    y;
		coord_t    z;
		wcrd_t     w;
		perm_set_t perm;
	} item_t;

	localparam val_t  ONE_V   = val_t'(1) <<< FRAC_BITS;
	localparam wcrd_t ONE_W   = wcrd_t'(1) <<< FRAC_BITS;
	localparam sml_t  ALPHA   = 25'sd12359;
	localparam val_t  BUB_C   = 36'sd6813374;
	localparam bval_t OUT_MAX = 19'sd262143;
	localparam bval_t OUT_MIN = -19'sd262144;

	// beta1..beta7
	localparam sml_t BETA [7] = '{-25'sd10028, 25'sd7698, -25'sd30790, -25'sd9323,
		25'sd6586, -25'sd2236, -25'sd6539};

	// coordinate codes: 0 = w, 1 = x, 2 = y, 3 = z
	localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

	// triple products: 0 = xyz, 1 = wyz, 2 = wxz, 3 = wxy
	localparam logic [1:0] BUB_TRI [12] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
	localparam logic [1:0] BUB_T [12] = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3,
		2'd3, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2};

	// mixing tables for the vertex and edge functions
	localparam dof_t MIX3 [4][3] = '{'{5'd13, 5'd18, 5'd19}, '{5'd12, 5'd17, 5'd20},
		'{5'd11, 5'd14, 5'd21}, '{5'd10, 5'd15, 5'd16}};
	localparam dof_t MIX6 [4][6] = '{
		'{5'd14, 5'd15, 5'd17, 5'd16, 5'd20, 5'd21},
		'{5'd10, 5'd11, 5'd16, 5'd18, 5'd19, 5'd21},
		'{5'd10, 5'd12, 5'd13, 5'd15, 5'd19, 5'd20},
		'{5'd11, 5'd12, 5'd14, 5'd13, 5'd17, 5'd18}};
	localparam dof_t MIX2 [6][2] = '{'{5'd16, 5'd21}, '{5'd15, 5'd20}, '{5'd14, 5'd17},
		'{5'd10, 5'd19}, '{5'd11, 5'd18}, '{5'd12, 5'd13}};
	localparam dof_t MIX4 [6][4] = '{'{5'd17, 5'd18, 5'd20, 5'd19},
		'{5'd13, 5'd14, 5'd21, 5'd19}, '{5'd13, 5'd15, 5'd16, 5'd18},
		'{5'd11, 5'd12, 5'd20, 5'd21}, '{5'd10, 5'd12, 5'd16, 5'd17},
		'{5'd10, 5'd11, 5'd14, 5'd15}};

	// fixed-point product, rounded to nearest with ties away from zero
	function automatic val_t mulq(input val_t a, input sml_t b);
		logic signed [PW-1:0] p;
		logic        [PW-1:0] m;
		logic        [PW-1:0] r;
		val_t                 rv;
		p  = a * b;
		m  = p[PW-1] ? PW'(-p) : PW'(p);
		r  = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		rv = val_t'(r[VW-1:0]);
		return p[PW-1] ? -rv : rv;
	endfunction

	// slot order of one face from its orientation code
	function automatic logic [2:0][1:0] face_slots(input logic [2:0] code);
		logic [1:0] s0;
		logic [1:0] s1;
		logic [1:0] s2;
		logic [1:0] t;
		s0 = 2'd0;
		s1 = 2'd1;
		s2 = 2'd2;
		if (code[2]) begin
			t = s0; s0 = s1; s1 = t;
		end
		if (code[1]) begin
			t = s1; s1 = s2; s2 = t;
		end
		if (code[0]) begin
			t = s0; s0 = s1; s1 = t;
		end
		return {s2, s1, s0};
	endfunction

	function automatic bval_t sat_out(input val_t v);
		if (v > val_t'(OUT_MAX)) return OUT_MAX;
		if (v < val_t'(OUT_MIN)) return OUT_MIN;
		return bval_t'(v[18:0]);
	endfunction

endpackage

FILE: rtl/core/tet_p2_bubble_basis_eval.sv
// top level of the quadratic plus bubble tetrahedral basis evaluator
//
// channel | direction | transfers                  | payload
// s_axis  | in        | one point per transfer     | tdata: x, y, z, face0..3 codes
// m_axis  | out       | 23 results per point       | tdata: dof_index, value; tlast
//
// one point produces 23 output transfers; the output serializer (one result per
// cycle while m_axis_tready holds high) sets the sustained rate and loads the next
// point as its last result is taken; the first result passes through the queue,
// the eight arithmetic stages and the serializer load; the queue is registered even when empty
// arst_n clears the queue, the stage valid bits and the serializer
// a stall on m_axis holds the serializer and then the pipeline; the queue keeps
// taking points until it is full
module tet_p2_bubble_basis_eval #(
	parameter int QUEUE_DEPTH = tpbe_pkg::Q_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // coord_x, coord_y, coord_z, face0..face3_orient
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // dof_index, basis_value
	output logic        m_axis_tlast    // is_last
);
	import tpbe_pkg::*;

	// front to queue
	logic  fq_valid;
	logic  fq_ready;
	item_t fq_item;

	// queue to back end
	logic  qb_valid;
	logic  qb_ready;
	item_t qb_item;

	// unpack, w = 1 - x - y - z, face slot tables
	tpbe_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.q_item        (fq_item)
	);

	// decouples input acceptance from the arithmetic back end
	tpbe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	// term products, beta mixing, saturation and result serializer
	tpbe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (qb_valid),
		.in_ready      (qb_ready),
		.in_item       (qb_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: rtl/core/tpbe_front.sv
// input side: unpacks a point, forms w and the face slot tables
module tpbe_front (
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [63:0]    s_axis_tdata,   // coord_x, coord_y, coord_z, face0..face3_orient
	output logic           q_valid,
	input  logic           q_ready,
	output tpbe_pkg::item_t q_item
);
	import tpbe_pkg::*;

	coord_t cx;
	coord_t cy;
	coord_t cz;

	assign cx = s_axis_tdata[16:0];
	assign cy = s_axis_tdata[33:17];
	assign cz = s_axis_tdata[50:34];

	always_comb begin
		q_item.x = cx;
		q_item.y = cy;
		q_item.z = cz;
		q_item.w = ONE_W - wcrd_t'({3'b000, cx}) - wcrd_t'({3'b000, cy})
			- wcrd_t'({3'b000, cz});
		for (int f = 0; f < NFACE; f++) begin
			q_item.perm[f] = face_slots(s_axis_tdata[51 + 3*f +: 3]);
		end
	end

	assign q_valid       = s_axis_tvalid;
	assign s_axis_tready = q_ready;

endmodule

FILE: rtl/core/tpbe_fifo.sv
// short item queue between the front and the arithmetic back end
module tpbe_fifo #(
	parameter int DEPTH = tpbe_pkg::Q_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tpbe_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output tpbe_pkg::item_t out_item
);
	import tpbe_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

FILE: rtl/core/tpbe_back.sv
// arithmetic pipeline and output serializer
module tpbe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tpbe_pkg::item_t in_item,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [23:0]     m_axis_tdata,  // dof_index, basis_value
	output logic            m_axis_tlast
);
	import tpbe_pkg::*;

	localparam dof_t LAST = dof_t'(NDOF - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv;
	logic ser_free;
	logic load;

	val_t crd_in [4];

	val_t      crd_s1 [4];
	sml_t      tm_s1 [4];
	val_t      qd_s1 [4];
	val_t      pr_s1 [6];
	perm_set_t perm_s1;

	val_t      l_s2 [10];
	val_t      tri_s2 [4];
	sml_t      tm_s2 [4];
	sml_t      z_s2;
	perm_set_t perm_s2;

	val_t      l_s3 [10];
	val_t      mb_s3 [12];
	val_t      l22p_s3;
	perm_set_t perm_s3;

	val_t      l_s4 [NDOF];
	perm_set_t perm_s4;

	val_t      l_s5 [NDOF];
	val_t      p3_s5 [4];
	val_t      p6_s5 [4][3];
	val_t      s2_s5 [6];
	val_t      p4_s5 [6][2];
	val_t      kb_s5 [3];
	perm_set_t perm_s5;

	val_t      l_s6 [NDOF];
	val_t      s3_s6 [4];
	val_t      s6_s6 [4];
	val_t      s2_s6 [6];
	val_t      s4_s6 [6];
	val_t      kb_s6 [3];
	perm_set_t perm_s6;

	val_t      l_s7 [NDOF];
	val_t      ua_s7 [10];
	val_t      ub_s7 [10];
	val_t      kb_s7 [2];
	perm_set_t perm_s7;

	val_t      f_s8 [NDOF];
	perm_set_t perm_s8;

	bval_t ser_val_q [NDOF];
	dof_t  ser_dof_q [NDOF];
	dof_t  cnt_q;
	logic  ser_vld_q;

	assign ser_free = !ser_vld_q || (m_axis_tready && cnt_q == LAST);
	assign adv      = !v_s8 || ser_free;
	assign load     = v_s8 && ser_free;
	assign in_ready = adv;

	always_comb begin
		crd_in[0] = val_t'(in_item.w);
		crd_in[1] = val_t'(in_item.x);
		crd_in[2] = val_t'(in_item.y);
		crd_in[3] = val_t'(in_item.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// s1: vertex quadratics, pair products, t - alpha
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				crd_s1[i] <= crd_in[i];
				tm_s1[i]  <= sml_t'(crd_in[i]) - ALPHA;
				qd_s1[i]  <= mulq(crd_in[i], sml_t'((crd_in[i] <<< 1) - ONE_V));
			end
			for (int j = 0; j < 6; j++) begin
				pr_s1[j] <= mulq(crd_in[PAIR_A[j]], sml_t'(crd_in[PAIR_B[j]]));
			end
			perm_s1 <= in_item.perm;
		end
	end

	// s2: edge terms, triple products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				l_s2[i]  <= qd_s1[i];
				tm_s2[i] <= tm_s1[i];
			end
			for (int j = 0; j < 6; j++) begin
				l_s2[4 + j] <= pr_s1[j] <<< 2;
			end
			tri_s2[0] <= mulq(pr_s1[3], sml_t'(crd_s1[3]));
			tri_s2[1] <= mulq(pr_s1[1], sml_t'(crd_s1[3]));
			tri_s2[2] <= mulq(pr_s1[0], sml_t'(crd_s1[3]));
			tri_s2[3] <= mulq(pr_s1[0], sml_t'(crd_s1[2]));
			z_s2      <= sml_t'(crd_s1[3]);
			perm_s2   <= perm_s1;
		end
	end

	// s3: bubble times (t - alpha), cell bubble product
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 10; i++) begin
				l_s3[i] <= l_s2[i];
			end
			for (int k = 0; k < 12; k++) begin
				mb_s3[k] <= mulq(tri_s2[BUB_TRI[k]], tm_s2[BUB_T[k]]);
			end
			l22p_s3 <= mulq(tri_s2[3], z_s2);
			perm_s3 <= perm_s2;
		end
	end

	// s4: bubble scale
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 10; i++) begin
				l_s4[i] <= l_s3[i];
			end
			for (int k = 0; k < 12; k++) begin
				l_s4[FACE_BASE + k] <= mulq(BUB_C, sml_t'(mb_s3[k]));
			end
			l_s4[NDOF-1] <= l22p_s3 <<< 8;
			perm_s4      <= perm_s3;
		end
	end

	// s5: first level of the sums, cell bubble weights
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s5 <= l_s4;
			for (int i = 0; i < 4; i++) begin
				p3_s5[i] <= l_s4[MIX3[i][0]] + l_s4[MIX3[i][1]];
				for (int j = 0; j < 3; j++) begin
					p6_s5[i][j] <= l_s4[MIX6[i][2*j]] + l_s4[MIX6[i][2*j+1]];
				end
			end
			for (int i = 0; i < 6; i++) begin
				s2_s5[i] <= l_s4[MIX2[i][0]] + l_s4[MIX2[i][1]];
				for (int j = 0; j < 2; j++) begin
					p4_s5[i][j] <= l_s4[MIX4[i][2*j]] + l_s4[MIX4[i][2*j+1]];
				end
			end
			for (int j = 0; j < 3; j++) begin
				kb_s5[j] <= mulq(l_s4[NDOF-1], BETA[4 + j]);
			end
			perm_s5 <= perm_s4;
		end
	end

	// s6: finish the sums
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s6  <= l_s5;
			kb_s6 <= kb_s5;
			s2_s6 <= s2_s5;
			for (int i = 0; i < 4; i++) begin
				s3_s6[i] <= p3_s5[i] + l_s5[MIX3[i][2]];
				s6_s6[i] <= p6_s5[i][0] + p6_s5[i][1] + p6_s5[i][2];
			end
			for (int i = 0; i < 6; i++) begin
				s4_s6[i] <= p4_s5[i][0] + p4_s5[i][1];
			end
			perm_s6 <= perm_s5;
		end
	end

	// s7: beta products, face bubble results
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < FACE_BASE; k++) begin
				l_s7[k] <= l_s6[k];
			end
			for (int k = FACE_BASE; k < NDOF - 1; k++) begin
				l_s7[k] <= l_s6[k] + kb_s6[2];
			end
			l_s7[NDOF-1] <= l_s6[NDOF-1];
			for (int i = 0; i < 4; i++) begin
				ua_s7[i] <= mulq(s3_s6[i], BETA[0]);
				ub_s7[i] <= mulq(s6_s6[i], BETA[1]);
			end
			for (int i = 0; i < 6; i++) begin
				ua_s7[4 + i] <= mulq(s2_s6[i], BETA[3]);
				ub_s7[4 + i] <= mulq(s4_s6[i], BETA[2]);
			end
			kb_s7[0] <= kb_s6[0];
			kb_s7[1] <= kb_s6[1];
			perm_s7  <= perm_s6;
		end
	end

	// s8: vertex and edge results
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				f_s8[i] <= l_s7[i] + ua_s7[i] + ub_s7[i] + kb_s7[0];
			end
			for (int i = 4; i < 10; i++) begin
				f_s8[i] <= l_s7[i] + ua_s7[i] + ub_s7[i] + kb_s7[1];
			end
			for (int k = FACE_BASE; k < NDOF; k++) begin
				f_s8[k] <= l_s7[k];
			end
			perm_s8 <= perm_s7;
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else if (load) begin
			ser_vld_q <= 1'b1;
			cnt_q     <= '0;
		end else if (ser_vld_q && m_axis_tready) begin
			if (cnt_q == LAST) begin
				ser_vld_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// serializer shift line, entry 0 is on the bus
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NDOF; k++) begin
				ser_val_q[k] <= sat_out(f_s8[k]);
			end
			for (int k = 0; k < FACE_BASE; k++) begin
				ser_dof_q[k] <= dof_t'(k);
			end
			for (int f = 0; f < NFACE; f++) begin
				for (int j = 0; j < 3; j++) begin
					ser_dof_q[FACE_BASE + 3*f + j] <= dof_t'(FACE_BASE + 3*f)
						+ dof_t'(perm_s8[f][j]);
				end
			end
			ser_dof_q[NDOF-1] <= LAST;
		end else if (ser_vld_q && m_axis_tready) begin
			for (int k = 0; k < NDOF - 1; k++) begin
				ser_val_q[k] <= ser_val_q[k + 1];
				ser_dof_q[k] <= ser_dof_q[k + 1];
			end
		end
	end

	assign m_axis_tvalid = ser_vld_q;
	assign m_axis_tdata  = {ser_val_q[0], ser_dof_q[0]};
	assign m_axis_tlast  = cnt_q == LAST;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q |-> cnt_q <= LAST)
		else $error("beat counter past last result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!ser_vld_q || (m_axis_tready && cnt_q == LAST)))
		else $error("serializer reloaded mid item");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ser_vld_q && m_axis_tready && cnt_q != LAST) |=>
		(ser_vld_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("beat counter skipped");

	a_hold_s8: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !adv) |=> (v_s8 && $stable(perm_s8)))
		else $error("last stage lost while stalled");

endmodule
